@@ sv/ttce_pkg.sv @@
// ----------------------------------------------------------------------------
// ttce_pkg
// Shared constants, command/status types and helpers for the text terminal
// cursor engine.
// ----------------------------------------------------------------------------
package ttce_pkg;

  localparam int DEF_SCREEN_COLUMNS = 80;
  localparam int DEF_SCREEN_ROWS    = 25;

  localparam int CHAR_W     = 8;
  localparam int ROW_W      = 5;
  localparam int COL_W      = 7;
  localparam int CELL_W     = 16;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 32;
  localparam int TAB_STEP   = 4;

  localparam logic [CHAR_W-1:0] CODE_NEWLINE    = 8'd10;
  localparam logic [CHAR_W-1:0] CODE_RETURN     = 8'd13;
  localparam logic [CHAR_W-1:0] CODE_TAB        = 8'd9;
  localparam logic [CHAR_W-1:0] CODE_BACKSPACE  = 8'd8;
  localparam logic [CHAR_W-1:0] CODE_BLANK      = 8'd32;
  localparam logic [CHAR_W-1:0] RESET_ATTRIBUTE = 8'd7;

  typedef enum logic [1:0] {
    KIND_CHAR,
    KIND_NEWLINE,
    KIND_TAB,
    KIND_BACK
  } kind_t;

  typedef enum logic [2:0] {
    MEM_NONE,
    MEM_WR_CHAR,
    MEM_WR_BLANK,
    MEM_RD_CELL,
    MEM_CLEAR,
    MEM_SCROLL
  } mem_op_t;

  typedef enum logic [2:0] {
    CUR_HOLD,
    CUR_ADVANCE,
    CUR_TAB,
    CUR_BACK,
    CUR_NEWLINE
  } cur_op_t;

  typedef struct packed {
    logic    load_item;
    logic    cnt_clr;
    logic    cnt_inc;
    mem_op_t mem_op;
    cur_op_t cur_op;
    logic    cap_cell;
    logic    load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic  is_read;
    kind_t kind;
    logic  last_row;
    logic  clear_last;
    logic  scroll_last;
    logic  out_free;
  } dp_sts_t;

  function automatic kind_t classify(input logic [CHAR_W-1:0] code);
    kind_t k;
    if (code == CODE_NEWLINE || code == CODE_RETURN) begin
      k = KIND_NEWLINE;
    end else if (code == CODE_TAB) begin
      k = KIND_TAB;
    end else if (code == CODE_BACKSPACE) begin
      k = KIND_BACK;
    end else begin
      k = KIND_CHAR;
    end
    return k;
  endfunction

endpackage

@@ sv/ttce_ram.sv @@
// ----------------------------------------------------------------------------
// ttce_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ttce_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/ttce_ctrl.sv @@
// ----------------------------------------------------------------------------
// ttce_ctrl
// Controller: sequences the clearing pass, put/read items, backspace, scroll
// and result hand-off.
// ----------------------------------------------------------------------------
module ttce_ctrl import ttce_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    s_axis_tvalid,
  output logic    s_axis_tready,
  output dp_cmd_t cmd,
  input  dp_sts_t sts
);

  typedef enum logic [6:0] {
    ST_CLEAR  = 7'b0000001,
    ST_IDLE   = 7'b0000010,
    ST_EXEC   = 7'b0000100,
    ST_RDWAIT = 7'b0001000,
    ST_BS2    = 7'b0010000,
    ST_SCROLL = 7'b0100000,
    ST_RESULT = 7'b1000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    s_axis_tready = 1'b0;
    cmd           = '{load_item: 1'b0, cnt_clr: 1'b0, cnt_inc: 1'b0,
                      mem_op: MEM_NONE, cur_op: CUR_HOLD,
                      cap_cell: 1'b0, load_out: 1'b0};
    case (state)
      ST_CLEAR: begin
        cmd.mem_op  = MEM_CLEAR;
        cmd.cnt_inc = 1'b1;
        if (sts.clear_last) begin
          cmd.cnt_clr = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          cmd.load_item = 1'b1;
          state_next    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (sts.is_read) begin
          cmd.mem_op = MEM_RD_CELL;
          state_next = ST_RDWAIT;
        end else begin
          case (sts.kind)
            KIND_CHAR: begin
              cmd.mem_op = MEM_WR_CHAR;
              cmd.cur_op = CUR_ADVANCE;
              state_next = ST_RESULT;
            end
            KIND_TAB: begin
              cmd.cur_op = CUR_TAB;
              state_next = ST_RESULT;
            end
            KIND_BACK: begin
              cmd.mem_op = MEM_WR_BLANK;
              cmd.cur_op = CUR_BACK;
              state_next = ST_BS2;
            end
            KIND_NEWLINE: begin
              cmd.cur_op = CUR_NEWLINE;
              state_next = sts.last_row ? ST_SCROLL : ST_RESULT;
            end
            default: begin
              state_next = ST_RESULT;
            end
          endcase
        end
      end
      ST_RDWAIT: begin
        cmd.cap_cell = 1'b1;
        state_next   = ST_RESULT;
      end
      ST_BS2: begin
        // second blank lands on the cell under the moved cursor
        cmd.mem_op = MEM_WR_BLANK;
        state_next = ST_RESULT;
      end
      ST_SCROLL: begin
        cmd.mem_op  = MEM_SCROLL;
        cmd.cnt_inc = 1'b1;
        if (sts.scroll_last) begin
          cmd.cnt_clr = 1'b1;
          state_next  = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

@@ sv/ttce_dp.sv @@
// ----------------------------------------------------------------------------
// ttce_dp
// Datapath: attribute register, item registers, cursor, sweep counter,
// screen store and output register.
// ----------------------------------------------------------------------------
module ttce_dp import ttce_pkg::*; #(
  parameter int SCREEN_COLUMNS = DEF_SCREEN_COLUMNS,
  parameter int SCREEN_ROWS    = DEF_SCREEN_ROWS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CHAR_W-1:0]     cfg_wdata,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  input  logic                  s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  input  dp_cmd_t               cmd,
  output dp_sts_t               sts
);

  localparam int CELLS    = SCREEN_ROWS * SCREEN_COLUMNS;
  localparam int AW       = $clog2(CELLS);
  localparam int CW       = $clog2(CELLS + 1);
  localparam int COPY_END = CELLS - SCREEN_COLUMNS;

  logic [CHAR_W-1:0] text_attribute;
  logic              item_func;
  logic [CHAR_W-1:0] item_code;
  logic [ROW_W-1:0]  item_row;
  logic [COL_W-1:0]  item_col;
  logic [ROW_W-1:0]  cur_row, cur_row_next;
  logic [COL_W-1:0]  cur_col, cur_col_next;
  logic [CW-1:0]     cnt;
  logic [CHAR_W-1:0] cell_char;
  logic [CHAR_W-1:0] cell_attr;

  logic              last_row;
  logic [ROW_W-1:0]  row_wrap;
  logic [COL_W:0]    col_inc;
  logic [COL_W:0]    col_tab;
  logic              in_range;
  logic              copy_phase;
  logic [AW-1:0]     cur_addr;
  logic [AW-1:0]     item_addr;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [CELL_W-1:0] ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [CELL_W-1:0] ram_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      text_attribute <= RESET_ATTRIBUTE;
    end else if (cfg_we) begin
      text_attribute <= cfg_wdata;
    end
  end

  // item fields: char_code, read_row, read_col from bit 0 up
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_func <= s_axis_tuser;
      item_code <= s_axis_tdata[7:0];
      item_row  <= s_axis_tdata[12:8];
      item_col  <= s_axis_tdata[19:13];
      cell_char <= '0;
      cell_attr <= '0;
    end else if (cmd.cap_cell) begin
      if (in_range) begin
        {cell_attr, cell_char} <= ram_rdata;
      end else begin
        {cell_attr, cell_char} <= '0;
      end
    end
  end

  // cursor
  assign last_row = (cur_row == ROW_W'(SCREEN_ROWS - 1));
  assign row_wrap = last_row ? '0 : cur_row + 1'b1;
  assign col_inc  = {1'b0, cur_col} + (COL_W+1)'(1);
  assign col_tab  = {1'b0, cur_col} + (COL_W+1)'(TAB_STEP);

  always_comb begin
    cur_row_next = cur_row;
    cur_col_next = cur_col;
    case (cmd.cur_op)
      CUR_ADVANCE: begin
        if (col_inc >= (COL_W+1)'(SCREEN_COLUMNS)) begin
          cur_row_next = row_wrap;
          cur_col_next = '0;
        end else begin
          cur_col_next = col_inc[COL_W-1:0];
        end
      end
      CUR_TAB: begin
        if (col_tab >= (COL_W+1)'(SCREEN_COLUMNS)) begin
          cur_row_next = row_wrap;
          cur_col_next = '0;
        end else begin
          cur_col_next = col_tab[COL_W-1:0];
        end
      end
      CUR_BACK: begin
        if (cur_col != '0) begin
          cur_col_next = cur_col - 1'b1;
        end
      end
      CUR_NEWLINE: begin
        // bottom row stays put; the controller runs the scroll
        cur_col_next = '0;
        if (!last_row) begin
          cur_row_next = cur_row + 1'b1;
        end
      end
      default: begin
        cur_row_next = cur_row;
        cur_col_next = cur_col;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_row <= '0;
      cur_col <= '0;
    end else begin
      cur_row <= cur_row_next;
      cur_col <= cur_col_next;
    end
  end

  // sweep counter for clearing and scrolling
  always_ff @(posedge clk) begin
    if (rst || cmd.cnt_clr) begin
      cnt <= '0;
    end else if (cmd.cnt_inc) begin
      cnt <= cnt + 1'b1;
    end
  end

  assign cur_addr   = AW'(cur_row * SCREEN_COLUMNS + cur_col);
  assign item_addr  = AW'(item_row * SCREEN_COLUMNS + item_col);
  assign in_range   = ({1'b0, item_row} < (ROW_W+1)'(SCREEN_ROWS)) &&
                      ({1'b0, item_col} < (COL_W+1)'(SCREEN_COLUMNS));
  // scroll: read one row ahead, write the beat read last cycle one cell back
  assign copy_phase = (cnt <= CW'(COPY_END));

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cur_addr;
    ram_wdata = {text_attribute, item_code};
    ram_raddr = cur_addr;
    case (cmd.mem_op)
      MEM_WR_CHAR: begin
        ram_we = 1'b1;
      end
      MEM_WR_BLANK: begin
        ram_we    = 1'b1;
        ram_wdata = {text_attribute, CODE_BLANK};
      end
      MEM_RD_CELL: begin
        ram_raddr = item_addr;
      end
      MEM_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(cnt);
        ram_wdata = {RESET_ATTRIBUTE, CODE_BLANK};
      end
      MEM_SCROLL: begin
        ram_raddr = AW'(cnt + CW'(SCREEN_COLUMNS));
        ram_we    = (cnt != '0);
        ram_waddr = AW'(cnt - 1'b1);
        ram_wdata = copy_phase ? ram_rdata : {text_attribute, CODE_BLANK};
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  ttce_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      m_axis_tdata <= {4'b0, cur_col, cur_row, cell_attr, cell_char};
    end
  end

  assign sts.is_read     = item_func;
  assign sts.kind        = classify(item_code);
  assign sts.last_row    = last_row;
  assign sts.clear_last  = (cnt == CW'(CELLS - 1));
  assign sts.scroll_last = (cnt == CW'(CELLS));
  assign sts.out_free    = !m_axis_tvalid || m_axis_tready;

endmodule

@@ sv/text_terminal_cursor_engine.sv @@
// An ordinary character, tab or plain newline passes through EXEC and RESULT before
// tvalid is registered; a read adds RDWAIT and a backspace adds BS2 (second store access).
// A newline on the bottom row adds a scroll sweep that copies each row up and blanks
// the bottom row, one store cell per cycle through the single write port.
// Items are handled one at a time, but the next item is taken while a result beat waits.
// Reset: cursor to 0,0, attribute to 7, then a clearing pass over all ROWS*COLS cells.
// ----------------------------------------------------------------------------
// text_terminal_cursor_engine
// Text-mode screen engine: character/attribute store with a cursor, put and
// read items over streams, one result beat per item.
// ----------------------------------------------------------------------------
module text_terminal_cursor_engine import ttce_pkg::*; #(
  parameter int SCREEN_COLUMNS = DEF_SCREEN_COLUMNS,
  parameter int SCREEN_ROWS    = DEF_SCREEN_ROWS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CHAR_W-1:0]     cfg_wdata,     // text_attribute
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // char_code, read_row, read_col, pad
  input  logic                  s_axis_tuser,  // func
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata   // cell_char, cell_attribute,
                                               // cursor_row, cursor_col, pad
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  ttce_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .cmd           (cmd),
    .sts           (sts)
  );

  ttce_dp #(
    .SCREEN_COLUMNS (SCREEN_COLUMNS),
    .SCREEN_ROWS    (SCREEN_ROWS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cmd           (cmd),
    .sts           (sts)
  );

endmodule
